/* sv/fcr_pkg.sv */
// ============================================================================
// fcr_pkg
// Shared types, constants and Q15 arithmetic helpers for the feedback comb
// reverb unit.
// ============================================================================
package fcr_pkg;

    localparam int STORE_DEPTH_DEF = 4096;

    localparam int SAMPLE_W    = 16;
    localparam int DELAY_LEN_W = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic signed [SAMPLE_W-1:0] DRY_GAIN_RST      = 16'sd6554;
    localparam logic signed [SAMPLE_W-1:0] WET_GAIN_RST      = 16'sd22938;
    localparam logic signed [SAMPLE_W-1:0] FEEDBACK_GAIN_RST = 16'sd26214;
    localparam logic [DELAY_LEN_W-1:0]     DELAY_LENGTH_RST  = 13'd3969;

    // 0.999 in Q15.
    localparam logic signed [SAMPLE_W-1:0] Q15_0999 = 16'sd32735;

    localparam logic signed [SAMPLE_W-1:0] Q15_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] Q15_MIN = 16'sh8000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // capture the request, start the delay-line read
        logic finish;   // write the delay line, load the result, advance
    } fcr_cmd_t;

    // Saturating Q15 product, floor rounding.
    function automatic logic signed [SAMPLE_W-1:0] q15_mul(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        logic signed [2*SAMPLE_W-1:0] p;
        p = a * b;
        if (a == Q15_MIN && b == Q15_MIN) begin
            return Q15_MAX;
        end
        return p[2*SAMPLE_W-2:SAMPLE_W-1];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] q15_sat(
        input logic signed [SAMPLE_W:0] v
    );
        if (v[SAMPLE_W] != v[SAMPLE_W-1]) begin
            return v[SAMPLE_W] ? Q15_MIN : Q15_MAX;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] q15_add(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        logic signed [SAMPLE_W:0] s;
        s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
        return q15_sat(s);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] q15_sub(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        logic signed [SAMPLE_W:0] s;
        s = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
        return q15_sat(s);
    endfunction

endpackage

/* sv/fcr_ctrl.sv */
// ============================================================================
// fcr_ctrl
// Controller: sequences one sample through the datapath and owns the
// handshakes of the sample and result channels.
// ============================================================================
module fcr_ctrl
    import fcr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output fcr_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    // The result register can take a new value when it is empty or being read.
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign cmd.accept = s_valid && s_ready;
    assign cmd.finish = (state_reg == ST_CALC) && out_free;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* sv/fcr_datapath.sv */
// ============================================================================
// fcr_datapath
// Datapath: configuration registers, delay line memory, circular position
// and the Q15 multiply and saturating add network.
// ============================================================================
module fcr_datapath
    import fcr_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fcr_cmd_t                   cmd,
    input  logic                       cfg_valid,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    output logic signed [SAMPLE_W-1:0] m_sample_out
);

    localparam int PTR_W = $clog2(STORE_DEPTH);
    localparam int CMP_W = (DELAY_LEN_W > PTR_W + 1) ? DELAY_LEN_W : PTR_W + 1;

    logic signed [SAMPLE_W-1:0] dry_gain_reg;
    logic signed [SAMPLE_W-1:0] wet_gain_reg;
    logic signed [SAMPLE_W-1:0] fb_gain_reg;
    logic [DELAY_LEN_W-1:0]     delay_length_reg;

    logic [PTR_W-1:0]           pos_reg;
    logic                       filled_reg;

    logic [PTR_W-1:0]           addr_reg;
    logic                       item_filled_reg;
    logic signed [SAMPLE_W-1:0] xw_reg;
    logic signed [SAMPLE_W-1:0] direct_reg;
    logic signed [SAMPLE_W-1:0] scale_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    logic signed [SAMPLE_W-1:0] store_mem [STORE_DEPTH];

    logic [CMP_W-1:0]           len_c;
    logic [CMP_W-1:0]           dl_ext;
    logic                       pos_past_end;
    logic [PTR_W-1:0]           pos_eff;
    logic [CMP_W-1:0]           pos_inc;
    logic                       wrap;
    logic signed [SAMPLE_W-1:0] fed;
    logic signed [SAMPLE_W-1:0] fb_term;
    logic signed [SAMPLE_W-1:0] wr_data;
    logic signed [SAMPLE_W-1:0] out_value;

    // A delay length of zero behaves as one; lengths above the store depth
    // are limited to the depth.
    assign dl_ext = CMP_W'(delay_length_reg);
    always_comb begin
        priority if (dl_ext == '0) begin
            len_c = CMP_W'(1);
        end else if (dl_ext > CMP_W'(STORE_DEPTH)) begin
            len_c = CMP_W'(STORE_DEPTH);
        end else begin
            len_c = dl_ext;
        end
    end

    // If the length was lowered to or below the current position, the line restarts
    // at zero and counts as filled.
    assign pos_past_end = CMP_W'(pos_reg) >= len_c;
    assign pos_eff      = pos_past_end ? '0 : pos_reg;

    assign pos_inc = CMP_W'(addr_reg) + CMP_W'(1);
    assign wrap    = pos_inc >= len_c;

    assign fed       = q15_mul(xw_reg, scale_reg);
    assign fb_term   = q15_mul(rd_data_reg, fb_gain_reg);
    assign wr_data   = item_filled_reg ? q15_add(fed, fb_term) : fed;
    assign out_value = item_filled_reg ? q15_add(direct_reg, rd_data_reg) : direct_reg;

    assign m_sample_out = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dry_gain_reg     <= DRY_GAIN_RST;
            wet_gain_reg     <= WET_GAIN_RST;
            fb_gain_reg      <= FEEDBACK_GAIN_RST;
            delay_length_reg <= DELAY_LENGTH_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DRY_GAIN:      dry_gain_reg     <= cfg_data;
                CFG_WET_GAIN:      wet_gain_reg     <= cfg_data;
                CFG_FEEDBACK_GAIN: fb_gain_reg      <= cfg_data;
                CFG_DELAY_LENGTH:  delay_length_reg <= cfg_data[DELAY_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            filled_reg <= 1'b0;
        end else if (cmd.finish) begin
            if (wrap) begin
                pos_reg    <= '0;
                filled_reg <= 1'b1;
            end else begin
                pos_reg    <= pos_inc[PTR_W-1:0];
                filled_reg <= item_filled_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            addr_reg        <= pos_eff;
            item_filled_reg <= filled_reg || pos_past_end;
            xw_reg          <= q15_mul(s_sample_in, wet_gain_reg);
            direct_reg      <= q15_mul(s_sample_in, dry_gain_reg);
            scale_reg       <= q15_sub(Q15_0999, fb_gain_reg);
        end
        if (cmd.finish) begin
            out_reg <= out_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rd_data_reg <= store_mem[pos_eff];
        end
        if (cmd.finish) begin
            store_mem[addr_reg] <= wr_data;
        end
    end

endmodule

/* sv/feedback_comb_reverb_unit.sv */
// ============================================================================
// feedback_comb_reverb_unit
// Q15 feedback comb reverb on signed 16-bit audio samples.
// ============================================================================
// For each sample, the delay line memory is first read at the current
// position while the input is scaled by the dry and wet gains; then the
// feedback product is formed, the new value is written back to the same
// position and the result is loaded into the output register. A new sample
// is taken only after that, so the unit does not accept a sample until the
// previous one is finished. A finished result waiting in the output register
// stalls the unit only when the next result is ready before it is taken.
// The delay line needs no clearing after reset: stored entries are only used
// once the line has filled.
// Configuration writes are accepted at any time but must only be issued while
// the unit is idle.
module feedback_comb_reverb_unit
    import fcr_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample_out
);

    fcr_cmd_t cmd;

    assign cfg_ready = 1'b1;

    fcr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    fcr_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_sample_in  (s_sample_in),
        .m_sample_out (m_sample_out)
    );

endmodule

/* sv/fcr_checker.sv */
// ============================================================================
// fcr_checker
// Port-level checks of the feedback comb reverb unit, bound to the top level.
// ============================================================================
module fcr_checker
    import fcr_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [SAMPLE_W-1:0] m_sample_out
);

    // A stalled result must hold its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out))
        else $error("result changed or dropped while stalled");

    // Only one sample is in flight at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // Ready only drops because a request was taken.
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid))
        else $error("ready dropped without an accepted request");

    // A fresh result appears only after the request that caused it.
    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result appeared without a matching request");

endmodule

bind feedback_comb_reverb_unit fcr_checker u_fcr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_out (m_sample_out)
);

/* sim/tb_feedback_comb_reverb_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_feedback_comb_reverb_unit
// Self-checking bench for the Q15 feedback comb reverb unit. The bench keeps
// its own copy of the delay line and the gain registers and predicts every
// output sample. It starts with a short directed script that includes a long
// first-pass fill of the delay line, then runs random phases of register
// writes and sample streams. Both handshakes stall in random bursts.
// ============================================================================
module tb_feedback_comb_reverb_unit;
    import fcr_pkg::*;

    localparam int LINE_DEPTH   = STORE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1080;
    localparam int QUIET_ITEMS  = 250;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic [1:0] {
        STEP_SAMPLE,
        STEP_WRITE,
        STEP_FILL
    } step_kind_t;

    typedef struct {
        step_kind_t             kind;
        logic [CFG_IDX_W-1:0]   sel;
        logic [CFG_DATA_W-1:0]  value;
        bit                     lit_ok;
        logic [SAMPLE_W-1:0]    lit;
    } script_step_t;

    logic                       aclk;
    logic                       aresetn      = 1'b0;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index    = '0;
    logic [CFG_DATA_W-1:0]      cfg_data     = '0;
    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in  = '0;
    logic                       m_valid;
    logic                       m_ready      = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample_out;

    // Predicted state of the unit.
    logic signed [SAMPLE_W-1:0] gain_dry;
    logic signed [SAMPLE_W-1:0] gain_wet;
    logic signed [SAMPLE_W-1:0] gain_fb;
    logic [DELAY_LEN_W-1:0]     delay_len;
    logic signed [SAMPLE_W-1:0] echo_line [LINE_DEPTH];
    int                         tap;
    bit                         wrapped;
    // Entries below this index have been written at least once.
    int                         written_count;

    logic signed [SAMPLE_W-1:0] pending_outputs [$];
    logic signed [SAMPLE_W-1:0] expected_now;
    bit                         quiet_tail = 1'b0;
    int                         stall_left = 0;
    int                         cycle_count = 0;
    int                         mismatches = 0;
    int                         outputs_checked = 0;
    int                         samples_sent = 0;
    int                         writes_done = 0;

    feedback_comb_reverb_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic signed [SAMPLE_W-1:0] clip16(input int v);
        if (v > 32767) return Q15_MAX;
        if (v < -32768) return Q15_MIN;
        return v[SAMPLE_W-1:0];
    endfunction

    // Floor-rounded Q15 product; only -1 times -1 can leave the range.
    function automatic logic signed [SAMPLE_W-1:0] q15_times(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        int p;
        p = int'(a) * int'(b);
        return clip16(p >>> 15);
    endfunction

    // Delay in use for a register value: zero acts as one, the depth caps it.
    function automatic int line_span(input logic [DELAY_LEN_W-1:0] len);
        if (len == '0) return 1;
        if (int'(len) > LINE_DEPTH) return LINE_DEPTH;
        return int'(len);
    endfunction

    task automatic comb_predict(
        input  logic signed [SAMPLE_W-1:0] x,
        output logic signed [SAMPLE_W-1:0] y
    );
        logic signed [SAMPLE_W-1:0] scale;
        logic signed [SAMPLE_W-1:0] fed;
        logic signed [SAMPLE_W-1:0] direct;
        logic signed [SAMPLE_W-1:0] delayed;
        int span;
        span   = line_span(delay_len);
        scale  = clip16(int'(Q15_0999) - int'(gain_fb));
        fed    = q15_times(q15_times(x, gain_wet), scale);
        direct = q15_times(x, gain_dry);
        // A shortened delay can leave the position past the new end.
        if (tap >= span) begin
            tap = 0;
            wrapped = 1'b1;
        end
        if (wrapped) begin
            delayed = echo_line[tap];
            echo_line[tap] = clip16(int'(fed) + int'(q15_times(delayed, gain_fb)));
            y = clip16(int'(direct) + int'(delayed));
        end else begin
            echo_line[tap] = fed;
            y = direct;
        end
        if (tap >= written_count) begin
            written_count = tap + 1;
        end
        tap++;
        if (tap >= span) begin
            tap = 0;
            wrapped = 1'b1;
        end
    endtask

    function automatic script_step_t step_row(
        input step_kind_t            kind,
        input logic [CFG_IDX_W-1:0]  sel,
        input logic [CFG_DATA_W-1:0] value,
        input bit                    lit_ok,
        input logic [SAMPLE_W-1:0]   lit
    );
        script_step_t s;
        s.kind   = kind;
        s.sel    = sel;
        s.value  = value;
        s.lit_ok = lit_ok;
        s.lit    = lit;
        return s;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return Q15_MAX;
            1: return Q15_MIN;
            2: return '0;
            3: return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_register_value(
        input logic [CFG_IDX_W-1:0] sel
    );
        logic [DELAY_LEN_W-1:0] len;
        if (sel == CFG_DELAY_LENGTH) begin
            case ($urandom_range(0, 15))
                0: len = '0;
                1: len = DELAY_LEN_W'(1);
                2: len = DELAY_LEN_W'(2);
                3: len = DELAY_LEN_W'(LINE_DEPTH);
                4: len = DELAY_LEN_W'($urandom_range(LINE_DEPTH + 1, 8191));
                5, 6: len = DELAY_LEN_W'($urandom_range(17, 600));
                default: len = DELAY_LEN_W'($urandom_range(1, 16));
            endcase
            // The bits above the length field are don't-care.
            return {3'($urandom_range(0, 7)), len};
        end
        case ($urandom_range(0, 9))
            0: return Q15_MIN;
            1: return Q15_MAX;
            2: return '0;
            3: return '1;
            4: return CFG_DATA_W'(1);
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // Drops both request valids and waits until every predicted output has been taken.
    task automatic settle();
        s_valid   <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(
        input logic [CFG_IDX_W-1:0]  sel,
        input logic [CFG_DATA_W-1:0] data
    );
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (sel)
            CFG_DRY_GAIN:      gain_dry  = data;
            CFG_WET_GAIN:      gain_wet  = data;
            CFG_FEEDBACK_GAIN: gain_fb   = data;
            CFG_DELAY_LENGTH:  delay_len = data[DELAY_LEN_W-1:0];
        endcase
        writes_done++;
    endtask

    task automatic push_sample(
        input logic signed [SAMPLE_W-1:0] x,
        input bit                         lit_ok,
        input logic signed [SAMPLE_W-1:0] lit
    );
        logic signed [SAMPLE_W-1:0] y;
        cfg_valid <= 1'b0;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= x;
        do @(posedge aclk); while (!s_ready);
        comb_predict(x, y);
        pending_outputs.push_back(lit_ok ? lit : y);
        samples_sent++;
    endtask

    // Output side: checks every accepted result and stalls in bursts.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("Unexpected output sample %0d with nothing pending",
                             m_sample_out);
                end
            end else begin
                expected_now = pending_outputs.pop_front();
                outputs_checked++;
                if (m_sample_out !== expected_now) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("Output %0d: sample_out expected %0d, got %0d",
                                 outputs_checked, expected_now, m_sample_out);
                    end
                end
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 14);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d outputs still pending",
                     cycle_count, pending_outputs.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        script_step_t          plan [$];
        logic [CFG_IDX_W-1:0]  reg_sel;
        int                    random_done;
        int                    phase_items;

        gain_dry  = DRY_GAIN_RST;
        gain_wet  = WET_GAIN_RST;
        gain_fb   = FEEDBACK_GAIN_RST;
        delay_len = DELAY_LENGTH_RST;
        tap       = 0;
        wrapped   = 1'b0;
        written_count = 0;
        random_done = 0;

        // Reset gains, delay line not yet filled: only the dry path shows.
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h0000, 1'b1, 16'h0000));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h7FFF, 1'b1, 16'd6553));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h8000, 1'b1, -16'sd6554));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'hFFFF, 1'b1, 16'hFFFF));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h0001, 1'b1, 16'h0000));
        // Minus one times minus one saturates to the largest positive value.
        plan.push_back(step_row(STEP_WRITE, CFG_DRY_GAIN, 16'h8000, 1'b0, '0));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h8000, 1'b1, 16'h7FFF));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h7FFF, 1'b1, -16'sd32767));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h0000, 1'b1, 16'h0000));
        // A length above the store depth acts as full depth, so this run stays
        // in the first pass and writes every entry it reaches.
        plan.push_back(step_row(STEP_WRITE, CFG_DELAY_LENGTH, 16'h1FFF, 1'b0, '0));
        plan.push_back(step_row(STEP_FILL, '0, 16'd600, 1'b0, '0));
        // Shortening the delay below the current position restarts at zero.
        plan.push_back(step_row(STEP_WRITE, CFG_DELAY_LENGTH, 16'd3, 1'b0, '0));
        plan.push_back(step_row(STEP_WRITE, CFG_WET_GAIN, 16'h7FFF, 1'b0, '0));
        plan.push_back(step_row(STEP_WRITE, CFG_FEEDBACK_GAIN, 16'h7FFF, 1'b0, '0));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h7FFF, 1'b0, '0));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h8000, 1'b0, '0));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h3039, 1'b0, '0));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'hFFFF, 1'b0, '0));
        // Most negative feedback saturates the input scale.
        plan.push_back(step_row(STEP_WRITE, CFG_FEEDBACK_GAIN, 16'h8000, 1'b0, '0));
        plan.push_back(step_row(STEP_WRITE, CFG_WET_GAIN, 16'h8000, 1'b0, '0));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h8000, 1'b0, '0));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h7FFF, 1'b0, '0));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h8000, 1'b0, '0));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h0000, 1'b0, '0));
        // A zero length behaves as a one-sample delay.
        plan.push_back(step_row(STEP_WRITE, CFG_DELAY_LENGTH, 16'h0000, 1'b0, '0));
        plan.push_back(step_row(STEP_WRITE, CFG_DRY_GAIN, 16'h7FFF, 1'b0, '0));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h7FFF, 1'b0, '0));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h8000, 1'b0, '0));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h0001, 1'b0, '0));
        plan.push_back(step_row(STEP_WRITE, CFG_DELAY_LENGTH, 16'h1000, 1'b0, '0));
        plan.push_back(step_row(STEP_WRITE, CFG_FEEDBACK_GAIN, 16'h0000, 1'b0, '0));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'hFFFF, 1'b0, '0));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h4E20, 1'b0, '0));
        plan.push_back(step_row(STEP_WRITE, CFG_DELAY_LENGTH, 16'hF001, 1'b0, '0));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'hB1E0, 1'b0, '0));
        plan.push_back(step_row(STEP_SAMPLE, '0, 16'h0000, 1'b0, '0));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            case (plan[i].kind)
                STEP_SAMPLE: push_sample(plan[i].value, plan[i].lit_ok, plan[i].lit);
                STEP_WRITE: begin
                    settle();
                    write_register(plan[i].sel, plan[i].value);
                end
                STEP_FILL: repeat (plan[i].value) push_sample(pick_sample(), 1'b0, '0);
                default: begin
                end
            endcase
        end

        while (random_done < RANDOM_ITEMS) begin
            settle();
            quiet_tail = (RANDOM_ITEMS - random_done) <= QUIET_ITEMS;
            repeat ($urandom_range(1, 4)) begin
                reg_sel = CFG_IDX_W'($urandom_range(0, 3));
                write_register(reg_sel, pick_register_value(reg_sel));
            end
            // Once the line has wrapped, a longer delay would reach entries
            // that were never written, so the delay is held to the written part.
            if (wrapped && line_span(delay_len) > written_count) begin
                write_register(CFG_DELAY_LENGTH, CFG_DATA_W'(written_count));
            end
            phase_items = $urandom_range(10, 120);
            if (phase_items > RANDOM_ITEMS - random_done) begin
                phase_items = RANDOM_ITEMS - random_done;
            end
            repeat (phase_items) push_sample(pick_sample(), 1'b0, '0);
            random_done += phase_items;
        end

        settle();
        repeat (8) @(posedge aclk);

        $display("Streamed %0d samples, with a long first-pass fill, across %0d register writes.",
                 samples_sent, writes_done);
        $display("Checked %0d output samples; %0d mismatches found.",
                 outputs_checked, mismatches);
        if (mismatches == 0 && pending_outputs.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
